// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/ctd_pkg.sv =====
// ----------------------------------------------------------------------------
// ctd_pkg
// types, character codes and helpers for the chunked transfer decoder
// ----------------------------------------------------------------------------
package ctd_pkg;

  localparam int SIZE_BITS_DEF = 31;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;

  // bytes dropped after each chunk's data
  localparam logic [1:0] SKIP_LEN = 2'd2;

  typedef enum logic [2:0] {
    MODE_LEAD  = 3'd0,
    MODE_DIGIT = 3'd1,
    MODE_TRAIL = 3'd2,
    MODE_EXT   = 3'd3,
    MODE_BAD   = 3'd4,
    MODE_DATA  = 3'd5,
    MODE_SKIP  = 3'd6,
    MODE_DONE  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_DECODING  = 2'd0,
    ST_TERMINATED = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       body_end;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CHAR_SP) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== rtl/ctd_parser.sv =====
// ----------------------------------------------------------------------------
// ctd_parser
// per-byte parse state and the result for the byte being accepted
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctd_parser #(
  parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              last_byte,
  output ctd_pkg::result_t  result
);

  typedef struct packed {
    ctd_pkg::mode_t         mode;
    logic [SIZE_BITS-1:0]   accum;
    logic                   seen;
  } line_t;

  ctd_pkg::mode_t   mode, mode_next, mode_proc;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic [SIZE_BITS-1:0] bytes_dec;
  logic [1:0]       skip_left, skip_left_next;
  logic [1:0]       skip_dec;
  logic             digit_seen, digit_seen_next;
  logic             pending_cr, pending_cr_next;
  ctd_pkg::status_t final_status, final_status_next, final_proc;

  // one size-line character applied to the line state
  function automatic line_t line_char(line_t cur, logic [7:0] c);
    line_t        r;
    ctd_pkg::hex_t h;
    r = cur;
    h = ctd_pkg::hex_digit(c);
    case (cur.mode) inside
      ctd_pkg::MODE_LEAD, ctd_pkg::MODE_DIGIT: begin
        if (ctd_pkg::is_ws(c)) begin
          if (cur.mode == ctd_pkg::MODE_DIGIT) r.mode = ctd_pkg::MODE_TRAIL;
        end else if (c == ctd_pkg::CHAR_SEMI) begin
          r.mode = ctd_pkg::MODE_EXT;
        end else if (h.valid) begin
          if (cur.accum[SIZE_BITS-1 -: 4] != 4'd0) begin
            r.mode = ctd_pkg::MODE_BAD;
          end else begin
            r.accum = {cur.accum[SIZE_BITS-5:0], h.value};
            r.seen  = 1'b1;
            r.mode  = ctd_pkg::MODE_DIGIT;
          end
        end else begin
          r.mode = ctd_pkg::MODE_BAD;
        end
      end
      ctd_pkg::MODE_TRAIL: begin
        if (ctd_pkg::is_ws(c)) begin
          r.mode = cur.mode;
        end else if (c == ctd_pkg::CHAR_SEMI) begin
          r.mode = ctd_pkg::MODE_EXT;
        end else begin
          r.mode = ctd_pkg::MODE_BAD;
        end
      end
      default: r = cur;
    endcase
    return r;
  endfunction

  line_t cur_line, line_a, line_b;

  assign bytes_dec = bytes_left - SIZE_BITS'(1);
  assign skip_dec  = skip_left - 2'd1;

  // next state
  always_comb begin
    mode_proc         = mode;
    size_accum_next   = size_accum;
    bytes_left_next   = bytes_left;
    skip_left_next    = skip_left;
    digit_seen_next   = digit_seen;
    pending_cr_next   = pending_cr;
    final_proc        = final_status;
    cur_line          = '{mode: mode, accum: size_accum, seen: digit_seen};
    line_a            = cur_line;
    line_b            = cur_line;
    if (accept) begin
      unique case (mode)
        ctd_pkg::MODE_DONE: begin
          mode_proc = mode;
        end
        ctd_pkg::MODE_DATA: begin
          bytes_left_next = bytes_dec;
          if (bytes_dec == '0) begin
            mode_proc      = ctd_pkg::MODE_SKIP;
            skip_left_next = ctd_pkg::SKIP_LEN;
          end
        end
        ctd_pkg::MODE_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == 2'd0) begin
            mode_proc       = ctd_pkg::MODE_LEAD;
            size_accum_next = '0;
            digit_seen_next = 1'b0;
            pending_cr_next = 1'b0;
          end
        end
        default: begin
          if (pending_cr && in_byte == ctd_pkg::CHAR_LF) begin
            // end of size line
            pending_cr_next = 1'b0;
            if (mode == ctd_pkg::MODE_LEAD) begin
              size_accum_next = '0;
              digit_seen_next = 1'b0;
            end else if (mode == ctd_pkg::MODE_BAD || !digit_seen) begin
              mode_proc  = ctd_pkg::MODE_DONE;
              final_proc = ctd_pkg::ST_MALFORMED;
            end else if (size_accum == '0) begin
              mode_proc  = ctd_pkg::MODE_DONE;
              final_proc = ctd_pkg::ST_TERMINATED;
            end else begin
              bytes_left_next = size_accum;
              mode_proc       = ctd_pkg::MODE_DATA;
            end
          end else begin
            // a held cr not followed by lf counts as whitespace
            if (pending_cr) line_a = line_char(cur_line, ctd_pkg::CHAR_CR);
            if (in_byte == ctd_pkg::CHAR_CR) begin
              pending_cr_next = 1'b1;
              line_b          = line_a;
            end else begin
              pending_cr_next = 1'b0;
              line_b          = line_char(line_a, in_byte);
            end
            mode_proc       = line_b.mode;
            size_accum_next = line_b.accum;
            digit_seen_next = line_b.seen;
          end
        end
      endcase
    end
    mode_next         = mode_proc;
    final_status_next = final_proc;
    if (accept && last_byte) begin
      mode_next         = ctd_pkg::MODE_LEAD;
      size_accum_next   = '0;
      bytes_left_next   = '0;
      skip_left_next    = 2'd0;
      digit_seen_next   = 1'b0;
      pending_cr_next   = 1'b0;
      final_status_next = ctd_pkg::ST_DECODING;
    end
  end

  // result for the accepted byte
  always_comb begin
    result.out_valid = (mode == ctd_pkg::MODE_DATA);
    result.out_byte  = (mode == ctd_pkg::MODE_DATA) ? in_byte : 8'd0;
    result.body_end  = last_byte;
    if (mode_proc == ctd_pkg::MODE_DONE) begin
      result.status = final_proc;
    end else if (last_byte) begin
      result.status = ctd_pkg::ST_TRUNCATED;
    end else begin
      result.status = ctd_pkg::ST_DECODING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ctd_pkg::MODE_LEAD;
      size_accum   <= '0;
      bytes_left   <= '0;
      skip_left    <= 2'd0;
      digit_seen   <= 1'b0;
      pending_cr   <= 1'b0;
      final_status <= ctd_pkg::ST_DECODING;
    end else begin
      mode         <= mode_next;
      size_accum   <= size_accum_next;
      bytes_left   <= bytes_left_next;
      skip_left    <= skip_left_next;
      digit_seen   <= digit_seen_next;
      pending_cr   <= pending_cr_next;
      final_status <= final_status_next;
    end
  end

  `ASSERT_IMPL(a_done_code, clk, rst, mode == ctd_pkg::MODE_DONE, final_status == ctd_pkg::ST_MALFORMED || final_status == ctd_pkg::ST_TERMINATED, "stopped parser without a final code")
  `ASSERT_IMPL(a_data_count, clk, rst, mode == ctd_pkg::MODE_DATA, bytes_left != '0, "data mode with no bytes left")
  `ASSERT_IMPL(a_skip_count, clk, rst, mode == ctd_pkg::MODE_SKIP, skip_left != 2'd0, "skip mode with nothing to skip")

endmodule

// ===== rtl/chunked_transfer_decoder.sv =====
// ----------------------------------------------------------------------------
// chunked_transfer_decoder
// strips chunk framing from an http chunked body, one byte per item
// ----------------------------------------------------------------------------
//  port group  dir  data                        meaning
//  s_axis      in   tdata: in_byte, tlast: end  encoded body bytes
//  m_axis      out  tdata: out_byte, tuser,     one result per input byte
//                   tlast: body_end
//
//  one item per cycle unless the output stalls; the result appears in the cycle after its byte is taken
//  the parse state update is a single pass of logic into the result register
//  rst is synchronous; after reset the parser waits for a size line
//  s_axis_tready drops only while a result is held and m_axis_tready is low
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chunked_transfer_decoder #(
  parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [0] out_valid, [2:1] status
  output logic       m_axis_tlast    // body_end
);

  logic             accept;
  ctd_pkg::result_t result;
  ctd_pkg::result_t out_reg;
  logic             out_vld;

  assign s_axis_tready = !out_vld || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ctd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (accept) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = out_reg.out_byte;
  assign m_axis_tuser  = {out_reg.status, out_reg.out_valid};
  assign m_axis_tlast  = out_reg.body_end;

  `ASSERT_IMPL(a_payload_status, clk, rst, m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast, m_axis_tuser[2:1] == ctd_pkg::ST_DECODING, "payload byte with a final status")
  `ASSERT_IMPL(a_idle_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0, "non-payload result carries data")
  `ASSERT_NEXT(a_result_after, clk, rst, accept, m_axis_tvalid && m_axis_tlast == $past(s_axis_tlast), "accepted byte gave no matching result")

endmodule
